### sv/tcw_pkg.sv
// Package for the text console writer: codes, controller states, datapath
// operations and the status bundle. Depends on nothing else.
package tcw_pkg;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] MARK_ATTR = 8'd0;
    localparam logic [7:0] COLOR_RST = 8'd7;
    localparam logic [2:0] TAB_SPAN  = 3'd4;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_UNDO   = 3'd1,
        REQ_SCR_UP = 3'd2,
        REQ_SCR_DN = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        CFG_CHAR_COLOR  = 2'd0,
        CFG_CLEAR_COLOR = 2'd1,
        CFG_INPUT_START = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_POPWAIT, S_EDIT, S_NL_FILL, S_TAB_FILL,
        S_BS_WAIT, S_BSN_CHK, S_BSN_WAIT, S_BST, S_SCROLL, S_RDWAIT, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LATCH, OP_POP, OP_LOADREC, OP_SCRUP, OP_SCRDN,
        OP_RDCELL, OP_RDDONE, OP_NL_START, OP_NL_FILL, OP_NL_END,
        OP_TAB_START, OP_TAB_FILL, OP_TAB_END, OP_CHAR, OP_BS_READ,
        OP_BSN_READ, OP_BSN_CLR, OP_BSN_END, OP_BST_CLR, OP_BST_END, OP_BSC,
        OP_AUTOSCR, OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic       clr_last;
        logic       undo_empty;
        logic       kind_nl;
        logic       kind_tab;
        logic       kind_bs;
        logic       nl_room;
        logic       tab_room;
        logic       chr_room;
        logic       bs_ok;
        logic [7:0] rd_char;
        logic       ptr_at_base;
        logic       cnt_full;
        logic       pcol_end;
        logic       need_scroll;
        logic [2:0] req;
        logic       out_free;
    } dp_status_t;

endpackage

### sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath one operation per cycle.
module tcw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  tcw_pkg::dp_status_t st,
    output logic                s_tready,
    output tcw_pkg::dp_op_t     op
);
    import tcw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (st.clr_last) state_next = S_IDLE;
            S_IDLE:    if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                priority case (st.req)
                    REQ_WRITE: state_next = S_EDIT;
                    REQ_UNDO:  state_next = st.undo_empty ? S_OUT : S_POPWAIT;
                    REQ_READ:  state_next = S_RDWAIT;
                    default:   state_next = S_OUT;
                endcase
            end
            S_POPWAIT: state_next = S_EDIT;
            S_EDIT: begin
                priority if (st.kind_nl) begin
                    state_next = st.nl_room ? S_NL_FILL : S_SCROLL;
                end else if (st.kind_tab) begin
                    state_next = st.tab_room ? S_TAB_FILL : S_SCROLL;
                end else if (st.kind_bs) begin
                    state_next = st.bs_ok ? S_BS_WAIT : S_SCROLL;
                end else begin
                    state_next = S_SCROLL;
                end
            end
            S_NL_FILL:  if (st.pcol_end) state_next = S_SCROLL;
            S_TAB_FILL: if (st.cnt_full) state_next = S_SCROLL;
            S_BS_WAIT: begin
                priority if (st.rd_char == CH_NL) state_next = S_BSN_CHK;
                else if (st.rd_char == CH_TAB) state_next = S_BST;
                else state_next = S_SCROLL;
            end
            S_BSN_CHK:  state_next = st.ptr_at_base ? S_SCROLL : S_BSN_WAIT;
            S_BSN_WAIT: state_next = (st.rd_char != CH_NUL) ? S_BSN_CHK : S_SCROLL;
            S_BST:      if (st.cnt_full || st.ptr_at_base) state_next = S_SCROLL;
            S_SCROLL:   if (!st.need_scroll) state_next = S_OUT;
            S_RDWAIT:   state_next = S_OUT;
            S_OUT:      if (st.out_free) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        op       = OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR: op = OP_CLEAR;
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = OP_LATCH;
            end
            S_DECODE: begin
                priority case (st.req)
                    REQ_UNDO:   if (!st.undo_empty) op = OP_POP;
                    REQ_SCR_UP: op = OP_SCRUP;
                    REQ_SCR_DN: op = OP_SCRDN;
                    REQ_READ:   op = OP_RDCELL;
                    default:    op = OP_NONE;
                endcase
            end
            S_POPWAIT: op = OP_LOADREC;
            S_EDIT: begin
                priority if (st.kind_nl) begin
                    if (st.nl_room) op = OP_NL_START;
                end else if (st.kind_tab) begin
                    if (st.tab_room) op = OP_TAB_START;
                end else if (st.kind_bs) begin
                    if (st.bs_ok) op = OP_BS_READ;
                end else begin
                    if (st.chr_room) op = OP_CHAR;
                end
            end
            S_NL_FILL:  op = st.pcol_end ? OP_NL_END : OP_NL_FILL;
            S_TAB_FILL: op = st.cnt_full ? OP_TAB_END : OP_TAB_FILL;
            S_BS_WAIT: begin
                priority if (st.rd_char == CH_NL) op = OP_BSN_CLR;
                else if (st.rd_char == CH_TAB) op = OP_NONE;
                else op = OP_BSC;
            end
            S_BSN_CHK:  op = st.ptr_at_base ? OP_BSN_END : OP_BSN_READ;
            S_BSN_WAIT: op = (st.rd_char != CH_NUL) ? OP_BSN_CLR : OP_BSN_END;
            S_BST:      op = (st.cnt_full || st.ptr_at_base) ? OP_BST_END : OP_BST_CLR;
            S_SCROLL:   if (st.need_scroll) op = OP_AUTOSCR;
            S_RDWAIT:   op = OP_RDDONE;
            S_OUT:      if (st.out_free) op = OP_OUT;
            default:    op = OP_NONE;
        endcase
    end

endmodule

### sv/tcw_dp.sv
// Datapath of the text console writer: cell memory, undo memory, cursor,
// screen start, configuration and result registers. Depends on tcw_pkg.
module tcw_dp #(
    parameter int CELLS        = 4096,
    parameter int ROW_WIDTH    = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int UNDO_DEPTH   = 2048,
    parameter int CONSOLE_BASE = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcw_pkg::dp_op_t     op,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [11:0]         cfg_wdata,
    input  logic [23:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tvalid,
    output tcw_pkg::dp_status_t st
);
    import tcw_pkg::*;

    localparam int PW0 = $clog2(CONSOLE_BASE + CELLS + SCREEN_CELLS + ROW_WIDTH + 1);
    localparam int PW  = (PW0 < 12) ? 12 : PW0;
    localparam int AW  = $clog2(CELLS);
    localparam int CW  = $clog2(ROW_WIDTH + 1);
    localparam int UW  = $clog2(UNDO_DEPTH);
    localparam int NW  = $clog2(UNDO_DEPTH + 1);
    localparam logic [PW-1:0] BASE_P   = PW'(CONSOLE_BASE);
    localparam logic [PW-1:0] END_P    = PW'(CONSOLE_BASE + CELLS);
    localparam logic [PW-1:0] ROW_P    = PW'(ROW_WIDTH);
    localparam logic [PW-1:0] SCREEN_P = PW'(SCREEN_CELLS);
    localparam logic [CW-1:0] ROW_C    = CW'(ROW_WIDTH);
    localparam logic [CW-1:0] ROW_LAST = CW'(ROW_WIDTH - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);
    localparam logic [UW-1:0] UNDO_LAST = UW'(UNDO_DEPTH - 1);
    localparam logic [NW-1:0] UNDO_FULL = NW'(UNDO_DEPTH);

    logic [15:0] cell_mem [CELLS];
    logic [8:0]  undo_mem [UNDO_DEPTH];

    logic [7:0]    char_color_reg, clear_color_reg;
    logic [11:0]   input_start_reg;
    logic [PW-1:0] cursor_reg, cursor_next, start_reg, start_next, ptr_reg, ptr_next;
    logic [CW-1:0] col_reg, col_next, pcol_reg, pcol_next;
    logic [2:0]    cnt_reg, cnt_next, req_reg, req_next;
    logic [7:0]    ch_reg, ch_next, rc_reg, rc_next, ra_reg, ra_next;
    logic          rec_en_reg, rec_en_next, rd_ok_reg, rd_ok_next;
    logic [11:0]   addr_reg, addr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [UW-1:0] top_reg, top_next;
    logic [NW-1:0] ucount_reg, ucount_next;
    logic [15:0]   cell_rdata_reg;
    logic [8:0]    undo_rdata_reg;
    logic [39:0]   out_data_reg, out_data_next;
    logic          out_valid_reg, out_valid_next;

    logic          cwe, cre, ure, push_en, push_del;
    logic [AW-1:0] cwa, cra;
    logic [15:0]   cwd;
    logic [7:0]    push_key;
    logic [UW-1:0] pop_idx;
    logic [PW-1:0] addr_ext, screen_end;

    function automatic logic [CW-1:0] col_inc(input logic [CW-1:0] c);
        return (c == ROW_LAST) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [CW-1:0] col_dec(input logic [CW-1:0] c);
        return (c == '0) ? ROW_LAST : c - 1'b1;
    endfunction

    function automatic logic [AW-1:0] cidx(input logic [PW-1:0] a);
        return AW'(a - BASE_P);
    endfunction

    assign addr_ext   = PW'(addr_reg);
    assign screen_end = start_reg + SCREEN_P;
    assign pop_idx    = (top_reg == '0) ? UNDO_LAST : top_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_color_reg  <= COLOR_RST;
            clear_color_reg <= COLOR_RST;
            input_start_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CHAR_COLOR:  char_color_reg  <= cfg_wdata[7:0];
                CFG_CLEAR_COLOR: clear_color_reg <= cfg_wdata[7:0];
                CFG_INPUT_START: input_start_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cursor_next = cursor_reg;  col_next = col_reg;
        start_next = start_reg;    ptr_next = ptr_reg;
        pcol_next = pcol_reg;      cnt_next = cnt_reg;
        req_next = req_reg;        ch_next = ch_reg;
        rec_en_next = rec_en_reg;  addr_next = addr_reg;
        rd_ok_next = rd_ok_reg;    rc_next = rc_reg;
        ra_next = ra_reg;          clr_next = clr_reg;
        top_next = top_reg;        ucount_next = ucount_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cwe = 1'b0; cwa = cidx(cursor_reg); cwd = '0;
        cre = 1'b0; cra = cidx(cursor_reg); ure = 1'b0;
        push_en = 1'b0; push_del = 1'b0; push_key = ch_reg;
        unique case (op)
            OP_CLEAR: begin
                cwe = 1'b1; cwa = clr_reg; cwd = {COLOR_RST, CH_SPACE};
                clr_next = clr_reg + 1'b1;
            end
            OP_LATCH: begin
                req_next = s_tuser; ch_next = s_tdata[7:0];
                addr_next = s_tdata[19:8]; rec_en_next = 1'b1;
                rc_next = '0; ra_next = '0;
            end
            OP_POP: begin
                ure = 1'b1; top_next = pop_idx; ucount_next = ucount_reg - 1'b1;
            end
            OP_LOADREC: begin
                ch_next = undo_rdata_reg[8] ? undo_rdata_reg[7:0] : CH_BS;
                rec_en_next = 1'b0;
            end
            OP_SCRUP: if (start_reg > BASE_P) start_next = start_reg - ROW_P;
            OP_SCRDN: if (screen_end < END_P) start_next = start_reg + ROW_P;
            OP_RDCELL: begin
                rd_ok_next = (addr_ext >= BASE_P) && (addr_ext < END_P);
                cre = 1'b1; cra = cidx(addr_ext);
            end
            OP_RDDONE: begin
                rc_next = rd_ok_reg ? cell_rdata_reg[7:0] : 8'd0;
                ra_next = rd_ok_reg ? cell_rdata_reg[15:8] : 8'd0;
            end
            OP_NL_START: begin
                cwe = 1'b1; cwd = {char_color_reg, CH_NUL};
                ptr_next = cursor_reg + 1'b1; pcol_next = col_reg + 1'b1;
            end
            OP_NL_FILL: begin
                cwe = 1'b1; cwa = cidx(ptr_reg); cwd = {MARK_ATTR, CH_NL};
                ptr_next = ptr_reg + 1'b1; pcol_next = pcol_reg + 1'b1;
            end
            OP_NL_END: begin
                cursor_next = ptr_reg; col_next = '0;
                push_en = rec_en_reg; push_key = CH_NL;
            end
            OP_TAB_START: begin
                ptr_next = cursor_reg; pcol_next = col_reg; cnt_next = '0;
            end
            OP_TAB_FILL: begin
                cwe = 1'b1; cwa = cidx(ptr_reg); cwd = {MARK_ATTR, CH_TAB};
                ptr_next = ptr_reg + 1'b1; pcol_next = col_inc(pcol_reg);
                cnt_next = cnt_reg + 1'b1;
            end
            OP_TAB_END, OP_BST_END: begin
                cursor_next = ptr_reg; col_next = pcol_reg;
                push_en = rec_en_reg; push_key = CH_TAB;
                push_del = (op == OP_BST_END);
            end
            OP_CHAR: begin
                cwe = 1'b1; cwd = {char_color_reg, ch_reg};
                cursor_next = cursor_reg + 1'b1; col_next = col_inc(col_reg);
                push_en = rec_en_reg;
            end
            OP_BS_READ: begin
                cre = 1'b1; cra = cidx(cursor_reg - 1'b1);
                ptr_next = cursor_reg; pcol_next = col_reg; cnt_next = '0;
            end
            OP_BSN_READ: begin
                cre = 1'b1; cra = cidx(ptr_reg - 1'b1);
            end
            OP_BSN_CLR, OP_BST_CLR: begin
                cwe = 1'b1; cwa = cidx(ptr_reg - 1'b1);
                cwd = {clear_color_reg, CH_SPACE};
                ptr_next = ptr_reg - 1'b1; pcol_next = col_dec(pcol_reg);
                cnt_next = cnt_reg + 1'b1;
            end
            OP_BSN_END: begin
                if (ptr_reg > BASE_P) begin
                    cursor_next = ptr_reg - 1'b1; col_next = col_dec(pcol_reg);
                end else begin
                    cursor_next = ptr_reg; col_next = pcol_reg;
                end
                push_en = rec_en_reg; push_del = 1'b1; push_key = CH_NL;
            end
            OP_BSC: begin
                cwe = 1'b1; cwa = cidx(cursor_reg - 1'b1);
                cwd = {clear_color_reg, CH_SPACE};
                cursor_next = cursor_reg - 1'b1; col_next = col_dec(col_reg);
                push_en = rec_en_reg; push_del = 1'b1;
                push_key = cell_rdata_reg[7:0];
            end
            OP_AUTOSCR: start_next = start_reg + ROW_P;
            OP_OUT: begin
                out_valid_next = 1'b1;
                out_data_next = {ra_reg, rc_reg, start_reg[11:0], cursor_reg[11:0]};
            end
            default: ;
        endcase
        if (push_en) begin
            top_next = (top_reg == UNDO_LAST) ? '0 : top_reg + 1'b1;
            if (ucount_reg != UNDO_FULL) ucount_next = ucount_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cwe) cell_mem[cwa] <= cwd;
        if (cre) cell_rdata_reg <= cell_mem[cra];
        if (push_en) undo_mem[top_reg] <= {push_del, push_key};
        if (ure) undo_rdata_reg <= undo_mem[pop_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= BASE_P;  col_reg <= '0;
            start_reg <= BASE_P;   ptr_reg <= BASE_P;
            pcol_reg <= '0;        cnt_reg <= '0;
            req_reg <= '0;         ch_reg <= '0;
            rec_en_reg <= 1'b0;    addr_reg <= '0;
            rd_ok_reg <= 1'b0;     rc_reg <= '0;
            ra_reg <= '0;          clr_reg <= '0;
            top_reg <= '0;         ucount_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;  col_reg <= col_next;
            start_reg <= start_next;    ptr_reg <= ptr_next;
            pcol_reg <= pcol_next;      cnt_reg <= cnt_next;
            req_reg <= req_next;        ch_reg <= ch_next;
            rec_en_reg <= rec_en_next;  addr_reg <= addr_next;
            rd_ok_reg <= rd_ok_next;    rc_reg <= rc_next;
            ra_reg <= ra_next;          clr_reg <= clr_next;
            top_reg <= top_next;        ucount_reg <= ucount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        st.clr_last    = (clr_reg == CLR_LAST);
        st.undo_empty  = (ucount_reg == '0);
        st.kind_nl     = (ch_reg == CH_NL);
        st.kind_tab    = (ch_reg == CH_TAB);
        st.kind_bs     = (ch_reg == CH_BS);
        st.nl_room     = (cursor_reg + ROW_P) < END_P;
        st.tab_room    = (cursor_reg + PW'(TAB_SPAN)) < END_P;
        st.chr_room    = (cursor_reg + 1'b1) < END_P;
        st.bs_ok       = (cursor_reg > PW'(input_start_reg)) && (cursor_reg > BASE_P);
        st.rd_char     = cell_rdata_reg[7:0];
        st.ptr_at_base = (ptr_reg == BASE_P);
        st.cnt_full    = (cnt_reg == TAB_SPAN);
        st.pcol_end    = (pcol_reg == ROW_C);
        st.need_scroll = (cursor_reg >= screen_end) && (screen_end < END_P);
        st.req         = req_reg;
        st.out_free    = !out_valid_reg || m_tready;
    end

endmodule

### sv/text_console_writer_with_undo.sv
// One request beat is taken at a time and answered with one result beat, registered in
// S_OUT. After S_DECODE a read passes S_RDWAIT, a write S_EDIT and S_SCROLL, and an undo
// S_POPWAIT before those. A newline repeats S_NL_FILL per filled marker, a newline
// backspace S_BSN_CHK and S_BSN_WAIT per cleared cell, and S_SCROLL per auto-scroll row.
// A held result stalls the input. After aresetn the cell memory is cleared to spaces, one
// cell a cycle, with s_tready low; configuration writes are taken throughout.
module text_console_writer_with_undo #(
    parameter int CELLS        = 4096,
    parameter int ROW_WIDTH    = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int UNDO_DEPTH   = 2048,
    parameter int CONSOLE_BASE = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code, cell_addr
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // cursor_pos, screen_start, cell_char, cell_attr
);
    import tcw_pkg::*;

    dp_op_t     op;
    dp_status_t st;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .s_tready (s_tready),
        .op       (op)
    );

    tcw_dp #(
        .CELLS        (CELLS),
        .ROW_WIDTH    (ROW_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .UNDO_DEPTH   (UNDO_DEPTH),
        .CONSOLE_BASE (CONSOLE_BASE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .st        (st)
    );

`ifndef NO_ASSERTIONS
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken before the first finished");

    a_no_output_during_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat during memory clear");
`endif

endmodule

### bench/text_console_writer_with_undo_tb.sv
// Self-checking testbench for text_console_writer_with_undo: directed and random
// console requests, with a local console model predicting each result beat.
// Depends on tcw_pkg and the text_console_writer_with_undo RTL.
module text_console_writer_with_undo_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int NCELLS   = 4096;
    localparam int ROW_W    = 80;
    localparam int SCR_N    = 2000;
    localparam int HIST_N   = 2048;
    localparam int SETTLE   = 400;
    localparam int MAX_CYC  = 3000000;

    typedef struct packed {
        logic [7:0]  attr;
        logic [7:0]  chr;
        logic [11:0] start;
        logic [11:0] cursor;
    } console_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // char_code, cell_addr
    logic [2:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // cursor_pos, screen_start, cell_char, cell_attr

    text_console_writer_with_undo dut (.*);

    always #2ns aclk = ~aclk;

    logic [15:0]  screen_mem [NCELLS];
    logic [8:0]   edit_hist [HIST_N];
    int           cursor_m, start_m, hist_cnt, hist_top;
    logic [7:0]   char_color_m, clear_color_m;
    int           input_start_m;
    console_out_t pending_results [$];
    int           errors = 0;
    int           cycles = 0;
    int           rx_hold = 0;
    bit           no_gaps = 0;
    int           nl_bias = 10;

    function automatic void put_cell(int a, logic [7:0] ch, logic [7:0] attr);
        if (a >= 0 && a < NCELLS) screen_mem[a] = {attr, ch};
    endfunction

    function automatic void push_edit(logic op, logic [7:0] key);
        edit_hist[hist_top] = {op, key};
        hist_top = (hist_top + 1 >= HIST_N) ? 0 : hist_top + 1;
        if (hist_cnt < HIST_N) hist_cnt++;
    endfunction

    function automatic void apply_edit(logic [7:0] ch, bit rec);
        int c, p, nc;
        logic [7:0] prev;
        c = cursor_m;
        if (ch == CH_NL) begin
            if (c + ROW_W < NCELLS) begin
                nc = ROW_W * (c / ROW_W + 1);
                put_cell(c, CH_NUL, char_color_m);
                for (int i = c + 1; i < nc; i++) put_cell(i, CH_NL, MARK_ATTR);
                cursor_m = nc;
                if (rec) push_edit(1'b0, CH_NL);
            end
        end else if (ch == CH_TAB) begin
            if (c + 4 < NCELLS) begin
                for (int i = 0; i < 4; i++) put_cell(c + i, CH_TAB, MARK_ATTR);
                cursor_m = c + 4;
                if (rec) push_edit(1'b0, CH_TAB);
            end
        end else if (ch == CH_BS) begin
            if (c > input_start_m && c > 0) begin
                prev = screen_mem[c - 1][7:0];
                p = c;
                if (prev == CH_NL) begin
                    while (p > 0 && screen_mem[p - 1][7:0] != CH_NUL) begin
                        p--;
                        put_cell(p, CH_SPACE, clear_color_m);
                    end
                    cursor_m = (p > 0) ? p - 1 : p;
                    if (rec) push_edit(1'b1, CH_NL);
                end else if (prev == CH_TAB) begin
                    for (int i = 0; i < 4 && p > 0; i++) begin
                        p--;
                        put_cell(p, CH_SPACE, clear_color_m);
                    end
                    cursor_m = p;
                    if (rec) push_edit(1'b1, CH_TAB);
                end else begin
                    if (rec) push_edit(1'b1, prev);
                    put_cell(c - 1, CH_SPACE, clear_color_m);
                    cursor_m = c - 1;
                end
            end
        end else if (c + 1 < NCELLS) begin
            put_cell(c, ch, char_color_m);
            cursor_m = c + 1;
            if (rec) push_edit(1'b0, ch);
        end
        while (cursor_m >= start_m + SCR_N && start_m + SCR_N < NCELLS) start_m += ROW_W;
    endfunction

    function automatic void predict_request(logic [2:0] req, logic [7:0] ch, logic [11:0] addr);
        console_out_t res;
        logic [8:0] rec;
        res = '0;
        case (req)
            REQ_WRITE: apply_edit(ch, 1'b1);
            REQ_UNDO: begin
                if (hist_cnt > 0) begin
                    hist_top = (hist_top == 0) ? HIST_N - 1 : hist_top - 1;
                    hist_cnt--;
                    rec = edit_hist[hist_top];
                    apply_edit(rec[8] ? rec[7:0] : CH_BS, 1'b0);
                end
            end
            REQ_SCR_UP: if (start_m > 0) start_m -= ROW_W;
            REQ_SCR_DN: if (start_m + SCR_N < NCELLS) start_m += ROW_W;
            REQ_READ: begin
                res.chr  = screen_mem[addr][7:0];
                res.attr = screen_mem[addr][15:8];
            end
            default: ;
        endcase
        res.cursor = cursor_m[11:0];
        res.start  = start_m[11:0];
        pending_results.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [2:0] req, logic [7:0] ch, logic [11:0] addr);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {4'b0, addr, ch};
        do @(posedge aclk); while (!s_tready);
        predict_request(req, ch, addr);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_CHAR_COLOR:  char_color_m = val[7:0];
            CFG_CLEAR_COLOR: clear_color_m = val[7:0];
            default:         input_start_m = int'(val);
        endcase
    endtask

    task automatic send_random();
        int r;
        logic [7:0] ch;
        logic [11:0] addr;
        r = $urandom_range(0, 99);
        addr = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'(cursor_m - $urandom_range(0, 8));
        if (r < 62) begin
            r = $urandom_range(0, 99);
            if (r < 22) ch = CH_BS;
            else if (r < 32) ch = CH_TAB;
            else if (r < 32 + nl_bias) ch = CH_NL;
            else ch = 8'($urandom_range(0, 255));
            send_request(REQ_WRITE, ch, addr);
        end else if (r < 76) send_request(REQ_UNDO, 8'($urandom), addr);
        else if (r < 82) send_request(REQ_SCR_UP, 8'($urandom), addr);
        else if (r < 88) send_request(REQ_SCR_DN, 8'($urandom), addr);
        else if (r < 97) send_request(REQ_READ, 8'($urandom), addr);
        else send_request(3'($urandom_range(5, 7)), 8'($urandom), addr);
    endtask

    task automatic test_directed();
        send_request(REQ_UNDO, 8'd0, 12'd0);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_SCR_UP, 8'd0, 12'd0);
        send_request(REQ_WRITE, 8'hFF, 12'd0);
        send_request(REQ_WRITE, 8'h00, 12'd0);
        send_request(REQ_WRITE, CH_TAB, 12'd0);
        send_request(REQ_WRITE, CH_NL, 12'd0);
        send_request(REQ_READ, 8'd0, 12'd0);
        send_request(REQ_READ, 8'd0, 12'd6);
        send_request(REQ_READ, 8'd0, 12'd79);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_UNDO, 8'd0, 12'd0);
        send_request(REQ_UNDO, 8'd0, 12'd0);
        send_request(REQ_UNDO, 8'd0, 12'd0);
        send_request(REQ_SCR_DN, 8'd0, 12'd0);
        send_request(REQ_SCR_UP, 8'd0, 12'd0);
        send_request(3'd5, 8'd0, 12'd0);
        send_request(3'd6, 8'd0, 12'd0);
        send_request(3'd7, 8'hAA, 12'hFFF);
        send_request(REQ_READ, 8'd0, 12'hFFF);
        drain();
    endtask

    task automatic test_colors_and_floor();
        write_reg(CFG_CHAR_COLOR, 12'hFF);
        write_reg(CFG_CLEAR_COLOR, 12'h00);
        write_reg(CFG_INPUT_START, 12'(cursor_m));
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_WRITE, 8'h41, 12'd0);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        send_request(REQ_WRITE, CH_BS, 12'd0);
        drain();
        write_reg(CFG_INPUT_START, 12'hFFF);
        repeat (60) send_random();
        drain();
        write_reg(CFG_INPUT_START, 12'h000);
        write_reg(CFG_CHAR_COLOR, 12'h00);
        write_reg(CFG_CLEAR_COLOR, 12'hFF);
    endtask

    task automatic test_random_typing(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_random();
        end
        no_gaps = 0;
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 500;
        no_gaps = 1;
        repeat (12) send_random();
        no_gaps = 0;
        drain();
        repeat (20) send_random();
        drain();
    endtask

    task automatic test_fill_to_end(int n);
        write_reg(CFG_CHAR_COLOR, 12'($urandom_range(0, 255)));
        write_reg(CFG_CLEAR_COLOR, 12'($urandom_range(0, 255)));
        nl_bias = 45;
        repeat (n) send_random();
        nl_bias = 10;
        drain();
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 99) < 6) begin
            m_tready <= 1'b0;
            rx_hold <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        console_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.cursor !== want.cursor) begin
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $realtime, want.cursor, got.cursor);
                    errors++;
                end
                if (got.start !== want.start) begin
                    $display("%0t: screen_start expected %0d actual %0d",
                             $realtime, want.start, got.start);
                    errors++;
                end
                if (got.chr !== want.chr) begin
                    $display("%0t: cell_char expected %h actual %h",
                             $realtime, want.chr, got.chr);
                    errors++;
                end
                if (got.attr !== want.attr) begin
                    $display("%0t: cell_attr expected %h actual %h",
                             $realtime, want.attr, got.attr);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NCELLS; i++) screen_mem[i] = {COLOR_RST, CH_SPACE};
        cursor_m = 0;
        start_m = 0;
        hist_cnt = 0;
        hist_top = 0;
        char_color_m = COLOR_RST;
        clear_color_m = COLOR_RST;
        input_start_m = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_colors_and_floor();
        test_random_typing(420);
        test_backpressure();
        test_random_typing(250);
        test_fill_to_end(340);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### files.f
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer_with_undo.sv
bench/text_console_writer_with_undo_tb.sv
